>>> design/tpa_pkg.sv
// Package for the triangle primitive assembler.
// Types and constants shared by the front, queue, back and top-level files.
package tpa_pkg;

    localparam int INDEX_BITS   = 32;
    localparam int FIELD_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int CORNERS      = 3;

    typedef enum logic [1:0] {
        MODE_LIST   = 2'd0,
        MODE_STRIP  = 2'd1,
        MODE_FAN    = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PRIM_MODE    = 2'd0,
        REG_VERTEX_COUNT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [FIELD_BITS-1:0] vertex_index;
        logic                  end_of_primitive;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] out_index;
        logic                  last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [1:0]            prim_mode;
        logic [FIELD_BITS-1:0] vertex_count;
    } t_cfg;

    typedef struct packed {
        logic [CORNERS-1:0][INDEX_BITS-1:0] corner;
        logic [CORNERS-1:0]                 mask;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> design/tpa_front.sv
// Front end: takes vertex indices, tracks strip/fan/list state, builds triangle jobs.
// Depends on tpa_pkg.
module tpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpa_pkg::t_cfg   i_cfg,
    input  logic            i_accept,
    input  tpa_pkg::t_in_item i_item,
    output logic            o_job_push,
    output tpa_pkg::t_job   o_job
);
    import tpa_pkg::*;

    logic [INDEX_BITS-1:0] r_older, n_older;
    logic [INDEX_BITS-1:0] r_newer, n_newer;
    logic [INDEX_BITS-1:0] r_center, n_center;
    logic [1:0]            r_seen, n_seen;
    logic                  r_parity, n_parity;

    logic [INDEX_BITS-1:0] cur;
    logic                  emit;
    t_mode                 mode;

    assign cur  = INDEX_BITS'(i_item.vertex_index);
    assign mode = t_mode'(i_cfg.prim_mode);

    always_comb begin
        n_older     = r_older;
        n_newer     = r_newer;
        n_center    = r_center;
        n_seen      = r_seen;
        n_parity    = r_parity;
        emit        = 1'b0;
        o_job.corner = '0;
        if (mode != MODE_UNUSED) begin
            if (r_seen < 2'd2) begin
                if (r_seen == 2'd0) begin
                    n_center = cur;
                end
                n_older = r_newer;
                n_newer = cur;
                n_seen  = r_seen + 2'd1;
            end else begin
                emit = 1'b1;
                o_job.corner[2] = cur;
                unique case (mode)
                    MODE_LIST: begin
                        o_job.corner[0] = r_older;
                        o_job.corner[1] = r_newer;
                        n_older = '0;
                        n_newer = '0;
                        n_seen  = 2'd0;
                    end
                    MODE_STRIP: begin
                        o_job.corner[0] = r_parity ? r_newer : r_older;
                        o_job.corner[1] = r_parity ? r_older : r_newer;
                        n_older  = r_newer;
                        n_newer  = cur;
                        n_parity = ~r_parity;
                    end
                    default: begin
                        o_job.corner[0] = r_center;
                        o_job.corner[1] = r_newer;
                        n_older = r_newer;
                        n_newer = cur;
                    end
                endcase
            end
        end
        if (i_item.end_of_primitive) begin
            n_older  = '0;
            n_newer  = '0;
            n_center = '0;
            n_seen   = 2'd0;
            n_parity = 1'b0;
        end
        for (int k = 0; k < CORNERS; k++) begin
            o_job.mask[k] = emit && (FIELD_BITS'(o_job.corner[k]) < i_cfg.vertex_count);
        end
        o_job_push = i_accept && (o_job.mask != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_newer  <= '0;
            r_center <= '0;
            r_seen   <= 2'd0;
            r_parity <= 1'b0;
        end else if (i_accept) begin
            r_older  <= n_older;
            r_newer  <= n_newer;
            r_center <= n_center;
            r_seen   <= n_seen;
            r_parity <= n_parity;
        end
    end

endmodule

>>> design/tpa_queue.sv
// Short job queue between the front and back ends.
// Depends on tpa_pkg.
module tpa_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpa_pkg::t_q_req  i_req,
    input  tpa_pkg::t_job    i_wdata,
    output tpa_pkg::t_q_stat o_stat,
    output tpa_pkg::t_job    o_rdata
);
    import tpa_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_req.push && !o_stat.full;
    assign do_pop       = i_req.pop && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/tpa_back.sv
// Back end: walks surviving corners, one result per cycle to the output register while popped.
// Depends on tpa_pkg.
module tpa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  tpa_pkg::t_job     i_job,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output tpa_pkg::t_out_item o_item
);
    import tpa_pkg::*;

    t_job               r_job;
    logic [CORNERS-1:0] r_mask;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [1:0]         sel;
    logic [CORNERS-1:0] sel_bit;
    logic [CORNERS-1:0] rem;
    logic               adv;
    logic               need;

    always_comb begin
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else begin
            sel = 2'd2;
        end
        sel_bit = CORNERS'(1) << sel;
        rem     = r_mask & ~sel_bit;
        adv     = (r_mask != '0) && (!r_out_valid || i_pop);
        need    = (r_mask == '0) || (adv && (rem == '0));
        o_q_pop = need && !i_q_empty;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
        if (adv) begin
            r_out.out_index   <= FIELD_BITS'(r_job.corner[sel]);
            r_out.last_of_run <= (rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mask <= i_job.mask;
            end else if (adv) begin
                r_mask <= rem;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> design/triangle_primitive_assembler.sv
// Top level of the triangle primitive assembler: config registers, front, queue, back.
// Depends on tpa_pkg, tpa_front, tpa_queue and tpa_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | push / full          | i_in_item  (vertex_index, end_of_primitive)
//  result   | pop / empty          | o_out_item (out_index, last_of_run)
//  config   | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// An index is taken every cycle while the job queue has room; each triangle
// produces up to three results, drained one per cycle by the back end while
// results are popped, so sustained throughput is set by the output register.
// Results pass through the job queue, the back end's job register and the output register.
// Synchronous active-low reset clears control state and config; no clearing pass. Config is always ready.
module triangle_primitive_assembler (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tpa_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output tpa_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [tpa_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [tpa_pkg::FIELD_BITS-1:0]   i_cfg_data
);
    import tpa_pkg::*;

    t_cfg    r_cfg;
    t_job    front_job;
    t_job    q_job;
    t_q_req  q_req;
    t_q_stat q_stat;
    logic    accept;
    logic    job_push;
    logic    job_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_stat.full;
    assign accept      = push && !q_stat.full;
    assign q_req       = {job_push, job_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PRIM_MODE:    r_cfg.prim_mode    <= i_cfg_data[1:0];
                REG_VERTEX_COUNT: r_cfg.vertex_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_item     (i_in_item),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    tpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .i_wdata (front_job),
        .o_stat  (q_stat),
        .o_rdata (q_job)
    );

    tpa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_job     (q_job),
        .o_q_pop   (job_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_req.push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_req.pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    a_job_has_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_req.push |-> front_job.mask != '0)
        else $error("job without surviving corner queued");

endmodule

>>> bench/triangle_primitive_assembler_tb.sv
// Testbench for triangle_primitive_assembler: list, strip and fan assembly checked transfer by
// transfer against an in-bench predictor, with directed cases, random primitives and back-pressure.
// Depends on tpa_pkg and the triangle_primitive_assembler RTL.
module triangle_primitive_assembler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpa_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 240;
    localparam int GAP_PERCENT   = 21;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    t_in_item                i_in_item = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    t_out_item               o_out_item;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [FIELD_BITS-1:0]   i_cfg_data = '0;

    triangle_primitive_assembler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    t_mode                 mode_reg = MODE_LIST;
    logic [FIELD_BITS-1:0] vcount_reg = '0;
    logic [INDEX_BITS-1:0] older_vtx = '0;
    logic [INDEX_BITS-1:0] newer_vtx = '0;
    logic [INDEX_BITS-1:0] center_vtx = '0;
    logic [1:0]            taken_cnt = '0;
    logic                  odd_strip = 1'b0;

    t_in_item  vertex_feed[$];
    t_out_item corners_due[$];
    int        fed_total = 0;
    int        accepted_total = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    bit        no_gaps = 1'b0;
    bit        hold_request = 1'b0;
    bit        hold_taken = 1'b0;
    int        hold_left = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_assembly();
        older_vtx  = '0;
        newer_vtx  = '0;
        center_vtx = '0;
        taken_cnt  = '0;
        odd_strip  = 1'b0;
    endfunction

    function automatic void assemble_triangle(input t_in_item item);
        logic [INDEX_BITS-1:0] cur;
        logic [INDEX_BITS-1:0] corner_q[3];
        t_out_item             res;
        bit                    closes;
        int                    last_k;
        cur    = item.vertex_index[INDEX_BITS-1:0];
        closes = 1'b0;
        if (mode_reg != MODE_UNUSED) begin
            if (taken_cnt < 2'd2) begin
                if (taken_cnt == 2'd0) center_vtx = cur;
                older_vtx = newer_vtx;
                newer_vtx = cur;
                taken_cnt = taken_cnt + 2'd1;
            end else begin
                closes = 1'b1;
                corner_q[2] = cur;
                case (mode_reg)
                    MODE_LIST: begin
                        corner_q[0] = older_vtx;
                        corner_q[1] = newer_vtx;
                        older_vtx   = '0;
                        newer_vtx   = '0;
                        taken_cnt   = '0;
                    end
                    MODE_STRIP: begin
                        corner_q[0] = odd_strip ? newer_vtx : older_vtx;
                        corner_q[1] = odd_strip ? older_vtx : newer_vtx;
                        older_vtx   = newer_vtx;
                        newer_vtx   = cur;
                        odd_strip   = ~odd_strip;
                    end
                    default: begin
                        corner_q[0] = center_vtx;
                        corner_q[1] = newer_vtx;
                        older_vtx   = newer_vtx;
                        newer_vtx   = cur;
                    end
                endcase
            end
        end
        if (closes) begin
            last_k = -1;
            for (int k = 0; k < CORNERS; k++)
                if (FIELD_BITS'(corner_q[k]) < vcount_reg) last_k = k;
            for (int k = 0; k < CORNERS; k++) begin
                if (FIELD_BITS'(corner_q[k]) < vcount_reg) begin
                    res.out_index   = FIELD_BITS'(corner_q[k]);
                    res.last_of_run = (k == last_k);
                    corners_due = {corners_due, res};
                end
            end
        end
        if (item.end_of_primitive) clear_assembly();
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                assemble_triangle(i_in_item);
                accepted_total++;
            end
            if (!push || !full) begin
                if (vertex_feed.size() > 0 &&
                        (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
                    i_in_item <= vertex_feed.pop_front();
                    push      <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop        <= 1'b0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (corners_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0h last %0b",
                        o_out_item.out_index, o_out_item.last_of_run));
                end else begin
                    want = corners_due.pop_front();
                    if (o_out_item.out_index !== want.out_index)
                        report_mismatch($sformatf("out_index %0h, expected %0h",
                            o_out_item.out_index, want.out_index));
                    if (o_out_item.last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("last_of_run %0b, expected %0b (index %0h)",
                            o_out_item.last_of_run, want.last_of_run, want.out_index));
                end
            end
            if (hold_request && !hold_taken) begin
                hold_taken <= 1'b1;
                hold_left  <= HOLD_CYCLES;
                pop        <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else begin
                pop <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic feed_vertex(input logic [FIELD_BITS-1:0] idx, input logic eop);
        t_in_item it;
        it.vertex_index     = idx;
        it.end_of_primitive = eop;
        vertex_feed = {vertex_feed, it};
        fed_total++;
    endtask

    task automatic wait_idle();
        while (accepted_total != fed_total || corners_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [FIELD_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_PRIM_MODE) mode_reg = t_mode'(data[1:0]);
        else vcount_reg = data;
    endtask

    task automatic set_config(input t_mode mode, input logic [FIELD_BITS-1:0] count);
        write_reg(REG_PRIM_MODE, FIELD_BITS'(mode));
        write_reg(REG_VERTEX_COUNT, count);
    endtask

    function automatic logic [FIELD_BITS-1:0] pick_index(input logic [FIELD_BITS-1:0] limit);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 12) return $urandom;
        if (r < 22) return limit - FIELD_BITS'($urandom_range(1));
        if (limit <= 64) return $urandom_range(limit + limit / 4 + 1);
        return $urandom_range(63);
    endfunction

    initial begin
        int               random_fed;
        int               prims;
        int               len;
        int               phase;
        int unsigned      r;
        t_mode            mode;
        logic [FIELD_BITS-1:0] count;
        bit               eop;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // list: extremes, a dropped corner, an incomplete tail, then an open pair
        set_config(MODE_LIST, '1);
        feed_vertex(32'h0, 1'b0);
        feed_vertex(32'hFFFF_FFFE, 1'b0);
        feed_vertex(32'h7, 1'b0);
        feed_vertex(32'hFFFF_FFFF, 1'b0);
        feed_vertex(32'h3, 1'b0);
        feed_vertex(32'h4, 1'b0);
        feed_vertex(32'h1, 1'b0);
        feed_vertex(32'h2, 1'b1);
        feed_vertex(32'hA, 1'b0);
        feed_vertex(32'hB, 1'b0);
        wait_idle();
        // mode switch mid-primitive: strip continues from the open pair
        write_reg(REG_PRIM_MODE, FIELD_BITS'(MODE_STRIP));
        feed_vertex(32'hC, 1'b0);
        feed_vertex(32'hD, 1'b0);
        feed_vertex(32'hE, 1'b1);
        wait_idle();
        set_config(MODE_FAN, 32'd6);
        feed_vertex(32'h5, 1'b0);
        feed_vertex(32'h1, 1'b0);
        feed_vertex(32'h9, 1'b0);
        feed_vertex(32'h2, 1'b0);
        feed_vertex(32'h3, 1'b1);
        wait_idle();
        // unused mode mid-primitive leaves state alone
        set_config(MODE_LIST, '1);
        feed_vertex(32'h14, 1'b0);
        wait_idle();
        write_reg(REG_PRIM_MODE, FIELD_BITS'(MODE_UNUSED));
        feed_vertex(32'h15, 1'b0);
        wait_idle();
        write_reg(REG_PRIM_MODE, FIELD_BITS'(MODE_LIST));
        feed_vertex(32'h16, 1'b0);
        feed_vertex(32'h17, 1'b1);
        wait_idle();
        set_config(MODE_LIST, '0);
        feed_vertex(32'h4, 1'b0);
        feed_vertex(32'h5, 1'b0);
        feed_vertex(32'h6, 1'b1);
        wait_idle();

        // long fan with the result side held off
        set_config(MODE_FAN, '1);
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) feed_vertex($urandom, i == 29);
        wait_idle();

        random_fed = 0;
        phase = 0;
        while (random_fed < RANDOM_ITEMS) begin
            r = $urandom_range(9);
            mode = (r == 0) ? MODE_UNUSED : t_mode'(2'($urandom_range(2)));
            r = $urandom_range(9);
            if (r == 0) count = '0;
            else if (r < 4) count = '1;
            else if (r == 4) count = $urandom;
            else count = $urandom_range(1, 40);
            set_config(mode, count);
            no_gaps = (phase >= 4) && (phase < 10);
            prims = $urandom_range(1, 4);
            for (int p = 0; p < prims; p++) begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++) begin
                    eop = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
                    feed_vertex(pick_index(count), eop);
                    random_fed++;
                end
            end
            wait_idle();
            phase++;
        end
        no_gaps = 1'b0;

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
design/tpa_pkg.sv
design/tpa_front.sv
design/tpa_queue.sv
design/tpa_back.sv
design/triangle_primitive_assembler.sv
bench/triangle_primitive_assembler_tb.sv
